// ----- sv/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, codes and banking helpers shared by the copier bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // bus access kinds
  typedef enum logic [1:0] {
    ACT_CPU_RD = 2'd0,
    ACT_CPU_WR = 2'd1,
    ACT_PPU_RD = 2'd2,
    ACT_PPU_WR = 2'd3
  } action_t;

  // local memory selects
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_PRG  = 3'd1,
    TGT_BIOS = 3'd2,
    TGT_CHR  = 3'd3,
    TGT_NT   = 3'd4
  } target_t;

  // copier phase
  typedef enum logic [2:0] {
    PH_PASS = 3'b001,
    PH_LOAD = 3'b010,
    PH_PLAY = 3'b100
  } phase_t;

  localparam int unsigned OffsetW = 17;

  // register offsets inside the 0x4000 page, and page numbers of the bus windows
  localparam logic [11:0] RegMode   = 12'h2FF;
  localparam logic [11:0] RegBank   = 12'h3FF;
  localparam logic [11:0] RegWakeHi = 12'hFFF;
  localparam logic [3:0]  CpuRegPage = 4'h4;
  localparam logic [3:0]  PrgLoLo    = 4'h6;
  localparam logic [3:0]  PrgLoHi    = 4'hD;
  localparam logic [3:0]  BiosLo     = 4'hE;
  localparam logic [5:0]  PaletteHi  = 6'h3F;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] play_mode;
    logic [7:0] bank_latch;
    logic       horizontal_mirror;
    logic [1:0] pattern_bank;
    logic [1:0] load_page;
    logic [2:0] low_page;
    logic [2:0] high_page;
  } map_state_t;

  typedef struct packed {
    target_t            local_target;
    logic [OffsetW-1:0] local_offset;
    logic               local_write;
    logic               pass_through;
  } map_result_t;

  typedef struct packed {
    logic [2:0] low_page;
    logic [2:0] high_page;
    logic [1:0] pattern_bank;
  } banking_t;

  // play-mode banking from mode and latch
  function automatic banking_t play_banking(input logic [2:0] mode, input logic [7:0] latch);
    banking_t b;
    b = '0;
    case (mode)
      3'd2: begin
        b.low_page = 3'd0; b.high_page = 3'd1; b.pattern_bank = 2'd0;
      end
      3'd4: begin
        b.low_page     = {latch[5:4], 1'b0};
        b.high_page    = {latch[5:4], 1'b1};
        b.pattern_bank = latch[1:0];
      end
      3'd5: begin
        b.low_page = 3'd6; b.high_page = 3'd7; b.pattern_bank = latch[1:0];
      end
      3'd6: begin
        b.low_page = 3'd6; b.high_page = 3'd7; b.pattern_bank = {1'b0, latch[0]};
      end
      3'd7: begin
        b.low_page = 3'd6; b.high_page = 3'd7; b.pattern_bank = 2'd0;
      end
      default: begin
        b.low_page = latch[2:0]; b.high_page = 3'd7; b.pattern_bank = 2'd0;
      end
    endcase
    return b;
  endfunction

endpackage

// ----- sv/cbm_if.sv -----
// ----------------------------------------------------------------------------
// cbm_in_if / cbm_out_if
// Valid/ready channels for bus accesses and mapping results.
// ----------------------------------------------------------------------------
interface cbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface cbm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  local_target;
  logic [16:0] local_offset;
  logic        local_write;
  logic        pass_through;

  modport source (output valid, local_target, local_offset, local_write, pass_through,
                  input ready);
  modport sink   (input valid, local_target, local_offset, local_write, pass_through,
                  output ready);
endinterface

// ----- sv/cbm_decode.sv -----
// ----------------------------------------------------------------------------
// cbm_decode
// Maps one bus access against the current state and gives the next state.
// ----------------------------------------------------------------------------
module cbm_decode (
  input  cbm_pkg::map_state_t  state,
  input  logic [1:0]           action,
  input  logic [15:0]          address,
  input  logic [7:0]           write_data,
  output cbm_pkg::map_result_t result,
  output cbm_pkg::map_state_t  state_nxt
);
  import cbm_pkg::*;

  logic [3:0]  bank;
  logic [11:0] off;
  logic [13:0] ppu_a;
  logic        is_load, is_play;
  logic        sel;
  logic [2:0]  page;
  banking_t    bk;

  assign bank    = address[15:12];
  assign off     = address[11:0];
  assign ppu_a   = address[13:0];
  assign is_load = (state.phase == PH_LOAD);
  assign is_play = (state.phase == PH_PLAY);
  assign sel     = state.horizontal_mirror ? ppu_a[11] : ppu_a[10];
  assign page    = bank[2] ? state.high_page : state.low_page;

  always_comb begin
    state_nxt = state;
    result    = '{local_target: TGT_NONE, local_offset: '0, local_write: 1'b0,
                  pass_through: 1'b1};
    bk        = '0;

    case (action)
      ACT_CPU_RD, ACT_CPU_WR: begin
        if (bank == CpuRegPage) begin
          if (action == ACT_CPU_WR) begin
            if (!is_load && !is_play) begin
              if (off == RegBank || off == RegWakeHi) state_nxt.phase = PH_LOAD;
            end else if (off == RegMode) begin
              state_nxt.phase             = PH_PLAY;
              state_nxt.play_mode         = write_data[7:5];
              state_nxt.horizontal_mirror = write_data[4];
              bk = play_banking(write_data[7:5], state.bank_latch);
              state_nxt.low_page     = bk.low_page;
              state_nxt.high_page    = bk.high_page;
              state_nxt.pattern_bank = bk.pattern_bank;
            end else if (off == RegBank) begin
              state_nxt.load_page    = write_data[5:4];
              state_nxt.pattern_bank = write_data[1:0];
              if (is_play) begin
                bk = play_banking(state.play_mode, state.bank_latch);
                state_nxt.low_page     = bk.low_page;
                state_nxt.high_page    = bk.high_page;
                state_nxt.pattern_bank = bk.pattern_bank;
              end
            end
          end
        end else if (is_load && bank >= PrgLoLo && bank <= PrgLoHi) begin
          result.local_target = TGT_PRG;
          result.local_offset = {state.load_page, bank[2:0], off};
          result.local_write  = (action == ACT_CPU_WR);
          result.pass_through = 1'b0;
        end else if (is_load && bank >= BiosLo) begin
          // writes to the BIOS go on to the bus only
          if (action == ACT_CPU_RD) begin
            result.local_target = TGT_BIOS;
            result.local_offset = {4'd0, bank[0], off};
            result.pass_through = 1'b0;
          end
        end else if (is_play && bank[3]) begin
          result.pass_through = 1'b0;
          if (action == ACT_CPU_WR) begin
            state_nxt.bank_latch = write_data;
            bk = play_banking(state.play_mode, write_data);
            state_nxt.low_page     = bk.low_page;
            state_nxt.high_page    = bk.high_page;
            state_nxt.pattern_bank = bk.pattern_bank;
          end else begin
            result.local_target = TGT_PRG;
            result.local_offset = {page, bank[1:0], off};
          end
        end
      end
      default: begin
        if (!ppu_a[13]) begin
          if (!is_load && !is_play) begin
            if (action == ACT_PPU_WR) begin
              result.local_target = TGT_CHR;
              result.local_offset = {2'd0, state.pattern_bank, ppu_a[12:0]};
              result.local_write  = 1'b1;
            end
          end else begin
            result.pass_through = 1'b0;
            if (action == ACT_PPU_RD || is_load || !state.play_mode[2]) begin
              result.local_target = TGT_CHR;
              result.local_offset = {2'd0, state.pattern_bank, ppu_a[12:0]};
              result.local_write  = (action == ACT_PPU_WR);
            end
          end
        end else if (is_play) begin
          result.pass_through = 1'b0;
          // palette writes stay out of the nametable
          if (!(action == ACT_PPU_WR && ppu_a[13:8] == PaletteHi)) begin
            result.local_target = TGT_NT;
            result.local_offset = {6'd0, sel, ppu_a[9:0]};
            result.local_write  = (action == ACT_PPU_WR);
          end
        end
      end
    endcase
  end

endmodule

// ----- sv/copier_bank_mapper_top.sv -----
// ----------------------------------------------------------------------------
// copier_bank_mapper_top
// Bank mapper of a cartridge copier: maps CPU and PPU accesses to local memory.
// ----------------------------------------------------------------------------
// One bus access per transaction, one result per access. An access is mapped
// against the banking state in the cycle it is accepted and the result is held
// in an output register, so the result appears in the cycle after acceptance and
// a new access is taken every cycle while the result side keeps up. Register
// and latch writes update the banking state at acceptance, so the very next
// access already sees the new mapping.
module copier_bank_mapper_top (
  input logic  clk,
  input logic  rst_n,
  cbm_in_if.sink    in_bus,
  cbm_out_if.source out_bus
);
  import cbm_pkg::*;

  map_state_t  state_r, state_nxt;
  map_result_t res_nxt, res_r;
  logic        out_valid_r;
  logic        in_fire;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  cbm_decode u_decode (
    .state      (state_r),
    .action     (in_bus.action),
    .address    (in_bus.address),
    .write_data (in_bus.write_data),
    .result     (res_nxt),
    .state_nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_PASS, play_mode: 3'd0, bank_latch: 8'd0,
                   horizontal_mirror: 1'b0, pattern_bank: 2'd0, load_page: 2'd0,
                   low_page: 3'd0, high_page: 3'd1};
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.local_target = res_r.local_target;
  assign out_bus.local_offset = res_r.local_offset;
  assign out_bus.local_write  = res_r.local_write;
  assign out_bus.pass_through = res_r.pass_through;

endmodule

// ----- tb/copier_bank_mapper_top_tb.sv -----
// ----------------------------------------------------------------------------
// copier_bank_mapper_top_tb
// Self-checking bench for the copier bank mapper. A short table of directed
// bus accesses takes the copier from pass-through through load into play and
// hits the address extremes and the ignored-write cases. It is followed by
// random play-phase traffic (mode, bank and latch writes mixed with CPU and
// PPU accesses) with random idling on both channels. Every result is checked
// against the predictor's mapping, or against the typed-in one for pinned rows.
// ----------------------------------------------------------------------------
module copier_bank_mapper_top_tb;
  import cbm_pkg::*;

  localparam int unsigned RandomAccesses = 1575;
  localparam int unsigned CalmTail       = 200;
  localparam int unsigned HoldAt         = 550;
  localparam int unsigned HoldCycles     = 48;
  localparam int unsigned StallLimit     = 1000;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned DirectedRows   = 25;

  typedef struct packed {
    action_t     act;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        pinned;
    target_t     tgt;
    logic [16:0] off;
    logic        wr;
    logic        pass;
  } access_row_t;

  // pinned rows carry the mapping typed in; others go to the predictor
  access_row_t directed_rows [0:DirectedRows-1] = '{
    '{ACT_CPU_RD, 16'h0000, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_PPU_WR, 16'h1FFF, 8'hA5, 1'b1, TGT_CHR,  17'h01FFF, 1'b1, 1'b1},
    '{ACT_PPU_RD, 16'hFFFF, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_PPU_RD, 16'h0000, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'h42FF, 8'hFF, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'h4FFF, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'h43FF, 8'h33, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'h6000, 8'h5A, 1'b1, TGT_PRG,  17'h1E000, 1'b1, 1'b0},
    '{ACT_CPU_RD, 16'hDFFF, 8'h00, 1'b1, TGT_PRG,  17'h1DFFF, 1'b0, 1'b0},
    '{ACT_CPU_RD, 16'hFFFF, 8'h00, 1'b1, TGT_BIOS, 17'h01FFF, 1'b0, 1'b0},
    '{ACT_CPU_WR, 16'hE000, 8'hC3, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_RD, 16'h5FFF, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_PPU_WR, 16'h1234, 8'h77, 1'b0, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_PPU_RD, 16'h2000, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'h42FF, 8'h90, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'hFFFF, 8'hFF, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_CPU_RD, 16'h8000, 8'h00, 1'b0, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_CPU_RD, 16'hFFFF, 8'h00, 1'b1, TGT_PRG,  17'h1FFFF, 1'b0, 1'b0},
    '{ACT_PPU_WR, 16'h0000, 8'hFF, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_PPU_RD, 16'h1FFF, 8'h00, 1'b0, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_PPU_WR, 16'h3F00, 8'h12, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_PPU_WR, 16'h2C00, 8'h34, 1'b0, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_PPU_RD, 16'h3FFF, 8'h00, 1'b0, TGT_NONE, 17'h00000, 1'b0, 1'b0},
    '{ACT_CPU_WR, 16'h43FF, 8'h00, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1},
    '{ACT_CPU_WR, 16'h42FF, 8'h40, 1'b1, TGT_NONE, 17'h00000, 1'b0, 1'b1}
  };

  logic clk;
  logic rst_n;

  cbm_in_if  in_ch ();
  cbm_out_if out_ch ();

  copier_bank_mapper_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  // banking predictor state
  phase_t      cp_phase;
  logic [2:0]  cp_mode;
  logic [7:0]  cp_latch;
  logic        cp_hmirror;
  logic [1:0]  cp_chr_bank;
  logic [1:0]  cp_load_page;
  logic [2:0]  cp_low_page;
  logic [2:0]  cp_high_page;
  logic [7:0]  modes_seen;

  map_result_t pending_maps[$];
  logic        pin_flag;
  map_result_t pin_want;

  int unsigned accesses_sent;
  int unsigned accesses_taken;
  int unsigned maps_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          calm;
  bit          hold_done;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic map_result_t mapping(input target_t t, input logic [16:0] o,
                                          input logic w, input logic p);
    map_result_t r;
    r.local_target = t;
    r.local_offset = o;
    r.local_write  = w;
    r.pass_through = p;
    return r;
  endfunction

  // play-mode banking from the current mode and latch
  function automatic void rebank();
    case (cp_mode)
      3'd2: begin
        cp_low_page = 3'd0; cp_high_page = 3'd1; cp_chr_bank = 2'd0;
      end
      3'd4: begin
        cp_low_page  = {cp_latch[5:4], 1'b0};
        cp_high_page = cp_low_page | 3'd1;
        cp_chr_bank  = cp_latch[1:0];
      end
      3'd5: begin
        cp_low_page = 3'd6; cp_high_page = 3'd7; cp_chr_bank = cp_latch[1:0];
      end
      3'd6: begin
        cp_low_page = 3'd6; cp_high_page = 3'd7; cp_chr_bank = {1'b0, cp_latch[0]};
      end
      3'd7: begin
        cp_low_page = 3'd6; cp_high_page = 3'd7; cp_chr_bank = 2'd0;
      end
      default: begin
        cp_low_page = cp_latch[2:0]; cp_high_page = 3'd7; cp_chr_bank = 2'd0;
      end
    endcase
  endfunction

  // maps one access and applies its register or latch side effects
  function automatic map_result_t map_access(input action_t act, input logic [15:0] addr,
                                             input logic [7:0] data);
    map_result_t r;
    logic [3:0]  page;
    logic [11:0] off;
    logic [13:0] pa;
    logic [2:0]  pg;
    logic        is_wr;
    logic        nt_sel;
    r     = mapping(TGT_NONE, '0, 1'b0, 1'b1);
    page  = addr[15:12];
    off   = addr[11:0];
    pa    = addr[13:0];
    is_wr = (act == ACT_CPU_WR) || (act == ACT_PPU_WR);
    if (act == ACT_CPU_RD || act == ACT_CPU_WR) begin
      if (page == CpuRegPage) begin
        if (is_wr) begin
          if (cp_phase == PH_PASS) begin
            if (off == RegBank || off == RegWakeHi) cp_phase = PH_LOAD;
          end else if (off == RegMode) begin
            cp_phase   = PH_PLAY;
            cp_mode    = data[7:5];
            cp_hmirror = data[4];
            modes_seen[data[7:5]] = 1'b1;
            rebank();
          end else if (off == RegBank) begin
            cp_chr_bank  = data[1:0];
            cp_load_page = data[5:4];
            if (cp_phase == PH_PLAY) rebank();
          end
        end
      end else if (cp_phase == PH_LOAD && page >= PrgLoLo && page <= PrgLoHi) begin
        r = mapping(TGT_PRG, {cp_load_page, page[2:0], off}, is_wr, 1'b0);
      end else if (cp_phase == PH_LOAD && page >= BiosLo) begin
        // writes to the bios window fall through to the bus
        if (!is_wr) r = mapping(TGT_BIOS, {4'd0, page[0], off}, 1'b0, 1'b0);
      end else if (cp_phase == PH_PLAY && page[3]) begin
        if (is_wr) begin
          cp_latch = data;
          rebank();
          r.pass_through = 1'b0;
        end else begin
          pg = (page < 4'hC) ? cp_low_page : cp_high_page;
          r  = mapping(TGT_PRG, {pg, page[1:0], off}, 1'b0, 1'b0);
        end
      end
    end else if (!pa[13]) begin
      if (cp_phase == PH_PASS) begin
        if (is_wr) r = mapping(TGT_CHR, {2'd0, cp_chr_bank, pa[12:0]}, 1'b1, 1'b1);
      end else if (!is_wr) begin
        r = mapping(TGT_CHR, {2'd0, cp_chr_bank, pa[12:0]}, 1'b0, 1'b0);
      end else if (cp_phase == PH_LOAD || cp_mode < 3'd4) begin
        r = mapping(TGT_CHR, {2'd0, cp_chr_bank, pa[12:0]}, 1'b1, 1'b0);
      end else begin
        r = mapping(TGT_NONE, '0, 1'b0, 1'b0);
      end
    end else if (cp_phase == PH_PLAY) begin
      nt_sel = cp_hmirror ? pa[11] : pa[10];
      if (is_wr && pa[13:8] == PaletteHi) r = mapping(TGT_NONE, '0, 1'b0, 1'b0);
      else r = mapping(TGT_NT, {6'd0, nt_sel, pa[9:0]}, is_wr, 1'b0);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [16:0] want,
                               input logic [16:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  // predict on input transactions, check on output transactions
  always @(posedge clk) begin
    map_result_t want;
    map_result_t got;
    if (!rst_n) begin
      cp_phase     = PH_PASS;
      cp_mode      = 3'd0;
      cp_latch     = 8'd0;
      cp_hmirror   = 1'b0;
      cp_chr_bank  = 2'd0;
      cp_load_page = 2'd0;
      cp_low_page  = 3'd0;
      cp_high_page = 3'd1;
      modes_seen   = 8'd0;
      pending_maps.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want = map_access(action_t'(in_ch.action), in_ch.address, in_ch.write_data);
        if (pin_flag) want = pin_want;
        pending_maps = {pending_maps, want};
        accesses_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = mapping(target_t'(out_ch.local_target), out_ch.local_offset,
                      out_ch.local_write, out_ch.pass_through);
        if (pending_maps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = pending_maps.pop_front();
          if (got.local_target !== want.local_target)
            flag_mismatch("local_target", 17'(want.local_target), 17'(got.local_target));
          if (got.local_offset !== want.local_offset)
            flag_mismatch("local_offset", want.local_offset, got.local_offset);
          if (got.local_write !== want.local_write)
            flag_mismatch("local_write", 17'(want.local_write), 17'(got.local_write));
          if (got.pass_through !== want.pass_through)
            flag_mismatch("pass_through", 17'(want.pass_through), 17'(got.pass_through));
          maps_checked++;
        end
      end
    end
  end

  // watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("copier_bank_mapper_top regression: fail");
        $finish;
      end
    end
  end

  // result side: random stall bursts, one long hold-off, none in the tail
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && accesses_sent >= HoldAt) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic drive_access(input action_t act, input logic [15:0] addr,
                              input logic [7:0] data, input logic pinned,
                              input map_result_t pin);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.address    <= addr;
    in_ch.write_data <= data;
    pin_flag         <= pinned;
    pin_want         <= pin;
    do @(posedge clk); while (!in_ch.ready);
    accesses_sent++;
  endtask

  initial begin
    int unsigned pick;
    action_t     act;
    logic [15:0] addr;
    logic [7:0]  data;
    access_row_t row;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_CPU_RD;
    in_ch.address    <= 16'h0000;
    in_ch.write_data <= 8'h00;
    pin_flag         <= 1'b0;
    pin_want         <= '0;
    rst_n            <= 1'b0;
    accesses_sent  = 0;
    accesses_taken = 0;
    maps_checked   = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    calm           = 1'b0;
    hold_done      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirectedRows; i++) begin
      row = directed_rows[i];
      drive_access(row.act, row.addr, row.data, row.pinned,
                   mapping(row.tgt, row.off, row.wr, row.pass));
    end

    // play-phase traffic: mostly well-formed banking, some raw noise
    for (int i = 0; i < RandomAccesses; i++) begin
      calm = (i >= RandomAccesses - CalmTail);
      pick = $urandom_range(0, 99);
      data = 8'($urandom);
      if (pick < 5) begin
        act  = ACT_CPU_WR;
        addr = {CpuRegPage, RegMode};
      end else if (pick < 10) begin
        act  = ACT_CPU_WR;
        addr = {CpuRegPage, RegBank};
      end else if (pick < 25) begin
        act  = ACT_CPU_WR;
        addr = {1'b1, 15'($urandom)};
      end else if (pick < 45) begin
        act  = ACT_CPU_RD;
        addr = {1'b1, 15'($urandom)};
      end else if (pick < 60) begin
        act  = $urandom_range(0, 1) ? ACT_PPU_WR : ACT_PPU_RD;
        addr = {2'($urandom), 1'b0, 13'($urandom)};
      end else if (pick < 70) begin
        act  = $urandom_range(0, 1) ? ACT_PPU_WR : ACT_PPU_RD;
        addr = {2'($urandom), 1'b1, 13'($urandom)};
      end else if (pick < 80) begin
        // palette window
        act  = $urandom_range(0, 1) ? ACT_PPU_WR : ACT_PPU_RD;
        addr = {2'($urandom), PaletteHi, 8'($urandom)};
      end else begin
        act  = action_t'($urandom_range(0, 3));
        addr = 16'($urandom);
      end
      drive_access(act, addr, data, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered: %0d accesses taken, %0d results checked, %0d mismatches",
             accesses_taken, maps_checked, mismatches);
    $display("covered: pass-through, load and play phases, play modes seen %b",
             modes_seen);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("copier_bank_mapper_top regression: pass");
    end else begin
      $display("copier_bank_mapper_top regression: fail");
    end
    $finish;
  end

endmodule
